FILE: sv/rtic_pkg.sv
// shared types and constants for the rigid tube inertia block
package rtic_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MASS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 8'd2;

  // register reset values, 1.0 in unsigned Q16.16
  localparam logic [31:0] MASS_RST   = 32'h0001_0000;
  localparam logic [31:0] RADIUS_RST = 32'h0001_0000;
  localparam logic [31:0] LENGTH_RST = 32'h0001_0000;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // divide by three: 16-bit quotient digits, reciprocal ceil(2^19 / 3)
  localparam int          DIV_STEPS  = 5;
  localparam logic [17:0] DIV3_RECIP = 18'd174763;

  // tensor component order: xx yy zz xy xz yz
  localparam int N_COMP = 6;
  localparam logic [1:0] PAIR_J [N_COMP] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
  localparam logic [1:0] PAIR_K [N_COMP] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  typedef enum logic [3:0] {
    ST_MUL_RR,
    ST_MUL_LL,
    ST_SUM,
    ST_MUL_A0,
    ST_MUL_A1,
    ST_MUL_R0,
    ST_MUL_R1,
    ST_ACC,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } coef_state_t;

  // per-configuration coefficients handed to the item pipeline
  typedef struct packed {
    logic        ready;
    logic [63:0] ip;
    logic [63:0] diff;
  } coef_t;

endpackage

FILE: sv/rtic_in_if.sv
// tube input channel
interface rtic_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        tube_index;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  modport source (
    output valid, tube_index, start_x, start_y, start_z, dir_x, dir_y, dir_z,
    input  ready
  );
  modport sink (
    input  valid, tube_index, start_x, start_y, start_z, dir_x, dir_y, dir_z,
    output ready
  );
endinterface

FILE: sv/rtic_out_if.sv
// result output channel
interface rtic_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        tube_tag;
  logic signed [63:0] inertia_xx;
  logic signed [63:0] inertia_yy;
  logic signed [63:0] inertia_zz;
  logic signed [63:0] inertia_xy;
  logic signed [63:0] inertia_xz;
  logic signed [63:0] inertia_yz;
  logic signed [31:0] centre_x;
  logic signed [31:0] centre_y;
  logic signed [31:0] centre_z;

  modport source (
    output valid, tube_tag, inertia_xx, inertia_yy, inertia_zz,
           inertia_xy, inertia_xz, inertia_yz, centre_x, centre_y, centre_z,
    input  ready
  );
  modport sink (
    input  valid, tube_tag, inertia_xx, inertia_yy, inertia_zz,
           inertia_xy, inertia_xz, inertia_yz, centre_x, centre_y, centre_z,
    output ready
  );
endinterface

FILE: sv/rtic_cfg_if.sv
// configuration write channel
interface rtic_cfg_if import rtic_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/rtic_coef.sv
// coefficient unit: Ip, Ia and Ia - Ip from mass, radius and length
module rtic_coef import rtic_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        restart,
  input  logic [31:0] mass,
  input  logic [31:0] radius,
  input  logic [31:0] length,
  output coef_t       coef
);

  coef_state_t state, state_next;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [47:0] r2;
  logic [50:0] a;
  logic [63:0] pa_lo;
  logic [82:0] pa;
  logic [63:0] pr_lo;
  logic [63:0] ia;
  logic [79:0] dvd;
  logic [79:0] quo;
  logic [1:0]  rem;
  logic [2:0]  cnt;
  logic [63:0] ip;
  logic [63:0] diff;

  logic [79:0] pr;
  logic [17:0] dnum;
  logic [35:0] dmul;
  logic [15:0] dq;
  logic [17:0] dq3;
  logic [1:0]  drem;
  logic [63:0] ip_sat;

  // next state
  always_comb begin
    case (state)
      ST_MUL_RR: state_next = ST_MUL_LL;
      ST_MUL_LL: state_next = ST_SUM;
      ST_SUM:    state_next = ST_MUL_A0;
      ST_MUL_A0: state_next = ST_MUL_A1;
      ST_MUL_A1: state_next = ST_MUL_R0;
      ST_MUL_R0: state_next = ST_MUL_R1;
      ST_MUL_R1: state_next = ST_ACC;
      ST_ACC:    state_next = ST_DIV;
      ST_DIV:    state_next = (cnt == 3'(DIV_STEPS - 1)) ? ST_FIN : ST_DIV;
      ST_FIN:    state_next = ST_DONE;
      ST_DONE:   state_next = ST_DONE;
      default:   state_next = ST_MUL_RR;
    endcase
    if (restart) begin
      state_next = ST_MUL_RR;
    end
  end

  // multiplier operand select
  always_comb begin
    case (state)
      ST_MUL_RR: begin
        mul_a = radius;
        mul_b = radius;
      end
      ST_MUL_LL: begin
        mul_a = length;
        mul_b = length;
      end
      ST_MUL_A0: begin
        mul_a = mass;
        mul_b = a[31:0];
      end
      ST_MUL_A1: begin
        mul_a = mass;
        mul_b = {13'd0, a[50:32]};
      end
      ST_MUL_R0: begin
        mul_a = mass;
        mul_b = r2[31:0];
      end
      ST_MUL_R1: begin
        mul_a = mass;
        mul_b = {16'd0, r2[47:32]};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign pr     = {prod[47:0], 32'd0} + {16'd0, pr_lo};
  // one quotient digit: floor(v / 3) by reciprocal multiply, v below 3 * 2^16
  assign dnum   = {rem, dvd[79:64]};
  assign dmul   = {18'd0, dnum} * {18'd0, DIV3_RECIP};
  assign dq     = dmul[34:19];
  assign dq3    = {1'b0, dq, 1'b0} + {2'b00, dq};
  assign drem   = 2'(dnum - dq3);
  assign ip_sat = (|quo[79:63]) ? S64_MAX : quo[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_MUL_RR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_MUL_LL: r2 <= prod[63:16];
      // a = 6*r2 + l2
      ST_SUM: a <= {1'b0, r2, 2'b00} + {2'b00, r2, 1'b0} + {3'd0, prod[63:16]};
      ST_MUL_A1: pa_lo <= prod;
      ST_MUL_R0: pa <= {prod[50:0], 32'd0} + {19'd0, pa_lo};
      ST_MUL_R1: pr_lo <= prod;
      ST_ACC: begin
        ia  <= pr[79] ? S64_MAX : pr[79:16];
        dvd <= {15'd0, pa[82:18]};
        quo <= '0;
        rem <= 2'd0;
        cnt <= 3'd0;
      end
      // divide by three, one 16-bit quotient digit a cycle
      ST_DIV: begin
        quo <= {quo[63:0], dq};
        rem <= drem;
        dvd <= {dvd[63:0], 16'd0};
        cnt <= cnt + 3'd1;
      end
      ST_FIN: begin
        ip   <= ip_sat;
        diff <= ia - ip_sat;
      end
      default: ;
    endcase
  end

  assign coef.ready = (state == ST_DONE);
  assign coef.ip    = ip;
  assign coef.diff  = diff;

endmodule

FILE: sv/rtic_pipe.sv
// per-tube pipeline: axis products, partial products, tensor terms, outputs
module rtic_pipe import rtic_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  coef_t       coef,
  input  logic [31:0] length,
  input  logic        cfg_write,
  rtic_in_if.sink     tube,
  rtic_out_if.source  result
);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  logic take;

  logic signed [15:0] t_in [3];
  logic signed [31:0] s_in [3];

  // stage 1
  logic [15:0]        tag1;
  logic signed [31:0] s1  [3];
  logic signed [31:0] tt1 [N_COMP];
  logic signed [47:0] lt1 [3];
  // stage 2
  logic [15:0]        tag2;
  logic signed [31:0] c2  [3];
  logic signed [64:0] pl2 [N_COMP];
  logic signed [63:0] ph2 [N_COMP];
  // stage 3
  logic [15:0]        tag3;
  logic signed [31:0] c3  [3];
  logic signed [63:0] term3 [N_COMP];
  // stage 4
  logic [15:0]        tag4;
  logic signed [31:0] c4  [3];
  logic signed [63:0] inr4 [N_COMP];

  assign en4  = !v4 || result.ready;
  assign en3  = !v3 || en4;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;
  assign tube.ready = en1 && coef.ready && !cfg_write;
  assign take = tube.valid && tube.ready;

  always_comb begin
    t_in[0] = tube.dir_x;
    t_in[1] = tube.dir_y;
    t_in[2] = tube.dir_z;
    s_in[0] = tube.start_x;
    s_in[1] = tube.start_y;
    s_in[2] = tube.start_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= take;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: direction products and length offsets
  always_ff @(posedge clk) begin
    logic signed [48:0] lt;
    if (en1) begin
      tag1 <= tube.tube_index;
      for (int i = 0; i < 3; i++) begin
        s1[i]  <= s_in[i];
        lt      = $signed({1'b0, length}) * t_in[i];
        lt1[i] <= 48'(lt);
      end
      for (int k = 0; k < N_COMP; k++) begin
        tt1[k] <= 32'(t_in[PAIR_J[k]] * t_in[PAIR_K[k]]);
      end
    end
  end

  // stage 2: diff split into halves, centre add with saturation
  always_ff @(posedge clk) begin
    logic signed [31:0] off;
    logic signed [33:0] cs;
    logic signed [64:0] pl;
    logic signed [63:0] ph;
    if (en2) begin
      tag2 <= tag1;
      for (int k = 0; k < N_COMP; k++) begin
        pl      = $signed({1'b0, coef.diff[31:0]}) * tt1[k];
        ph      = $signed(coef.diff[63:32]) * tt1[k];
        pl2[k] <= pl;
        ph2[k] <= ph;
      end
      for (int i = 0; i < 3; i++) begin
        off = 32'(lt1[i] >>> 16);
        cs  = 34'(s1[i]) + 34'(off);
        if ((cs[33] != cs[31]) || (cs[32] != cs[31])) begin
          c2[i] <= cs[33] ? S32_MIN : S32_MAX;
        end else begin
          c2[i] <= cs[31:0];
        end
      end
    end
  end

  // stage 3: combine partial products, floor by 2^30
  always_ff @(posedge clk) begin
    logic signed [95:0] p;
    if (en3) begin
      tag3 <= tag2;
      c3   <= c2;
      for (int k = 0; k < N_COMP; k++) begin
        p         = $signed({ph2[k], 32'd0}) + 96'(pl2[k]);
        term3[k] <= p[93:30];
      end
    end
  end

  // stage 4: add Ip on the diagonal, saturate upward
  always_ff @(posedge clk) begin
    logic signed [64:0] ds;
    if (en4) begin
      tag4 <= tag3;
      c4   <= c3;
      for (int k = 0; k < N_COMP; k++) begin
        if (k < 3) begin
          ds = $signed({1'b0, coef.ip}) + 65'(term3[k]);
          inr4[k] <= (!ds[64] && ds[63]) ? S64_MAX : ds[63:0];
        end else begin
          inr4[k] <= term3[k];
        end
      end
    end
  end

  assign result.valid      = v4;
  assign result.tube_tag   = tag4;
  assign result.inertia_xx = inr4[0];
  assign result.inertia_yy = inr4[1];
  assign result.inertia_zz = inr4[2];
  assign result.inertia_xy = inr4[3];
  assign result.inertia_xz = inr4[4];
  assign result.inertia_yz = inr4[5];
  assign result.centre_x   = c4[0];
  assign result.centre_y   = c4[1];
  assign result.centre_z   = c4[2];

endmodule

FILE: sv/rigid_tube_inertia_and_com.sv
// throughput: one tube per cycle through the four-stage multiplier pipeline
// while the output is not back-pressured; results leave from stage 4
// after reset and after every configuration write the input is held off
// while the coefficient unit recomputes Ip and Ia (one shared 32x32
// multiplier, then a five-step divide by three, 16 bits a step)
// reset: synchronous, clears valid bits, reloads mass, radius, length to 1.0
module rigid_tube_inertia_and_com import rtic_pkg::*; (
  input logic        clk,
  input logic        rst,
  rtic_cfg_if.sink   cfg,
  rtic_in_if.sink    tube,
  rtic_out_if.source result
);

  // configuration registers, unsigned Q16.16
  logic [31:0] mass;
  logic [31:0] radius;
  logic [31:0] length;

  coef_t coef;
  logic  cfg_write;

  // writes are always taken
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass   <= MASS_RST;
      radius <= RADIUS_RST;
      length <= LENGTH_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MASS:   mass   <= cfg.data;
        REG_RADIUS: radius <= cfg.data;
        REG_LENGTH: length <= cfg.data;
        // unknown index: write dropped
        default: ;
      endcase
    end
  end

  // any write restarts the coefficient computation; tube beats wait for it
  rtic_coef u_coef (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_write),
    .mass    (mass),
    .radius  (radius),
    .length  (length),
    .coef    (coef)
  );

  // tensor term = floor((Ia - Ip) * t_j * t_k / 2^30), diagonal adds Ip;
  // centre = start + floor(l * t / 2^16)
  rtic_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .length    (length),
    .cfg_write (cfg_write),
    .tube      (tube),
    .result    (result)
  );

endmodule
